### src/arm_ie_pkg.sv
// Shared types, constants and helper functions of the ARM instruction execute block.
// No dependencies; the register file, data memory and top level refer to this package by scoped names.
package arm_ie_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
  localparam int unsigned ROWS      = MEM_BYTES / 4;
  localparam int unsigned ROW_W     = ADDR_W - 2;
  localparam int unsigned LIM_W     = 17;
  localparam int unsigned CNT_W     = 48;

  localparam logic [31:0] SP_RESET = 32'(MEM_BYTES - 4);
  localparam logic [3:0]  REG_SP   = 4'd13;
  localparam logic [3:0]  REG_LR   = 4'd14;
  localparam logic [3:0]  REG_PC   = 4'd15;
  localparam logic [4:0]  IDX_PSR  = 5'd16;

  typedef enum logic [2:0] {
    MODE_EXEC   = 3'd0,
    MODE_REG_WR = 3'd1,
    MODE_REG_RD = 3'd2,
    MODE_MEM_WR = 3'd3,
    MODE_MEM_RD = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    RES_DONE    = 2'd0,
    RES_SKIP    = 2'd1,
    RES_UNKNOWN = 2'd2,
    RES_RANGE   = 2'd3
  } result_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EX,
    S_EX2
  } fsm_e;

  typedef enum logic [3:0] {
    OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
    OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
    OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
    OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
  } op_e;

  typedef enum logic [3:0] {
    CC_EQ = 4'h0, CC_NE = 4'h1, CC_CS = 4'h2, CC_CC = 4'h3,
    CC_MI = 4'h4, CC_PL = 4'h5, CC_VS = 4'h6, CC_VC = 4'h7,
    CC_HI = 4'h8, CC_LS = 4'h9, CC_GE = 4'hA, CC_LT = 4'hB,
    CC_GT = 4'hC, CC_LE = 4'hD, CC_AL = 4'hE, CC_NV = 4'hF
  } cond_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
  } shift_e;

  typedef enum logic [1:0] {
    CLS_DATA   = 2'd0,
    CLS_MEM    = 2'd1,
    CLS_BRANCH = 2'd2,
    CLS_OTHER  = 2'd3
  } class_e;

  typedef struct packed {
    logic              en;
    logic              word;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } dmem_wr_t;

  function automatic logic [31:0] reg_reset(input logic [3:0] idx);
    return (idx == REG_SP) ? SP_RESET : 32'd0;
  endfunction

  function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] nzcv);
    logic n, z, cy, v, r;
    n  = nzcv[3];
    z  = nzcv[2];
    cy = nzcv[1];
    v  = nzcv[0];
    case (c)
      CC_EQ:   r = z;
      CC_NE:   r = !z;
      CC_CS:   r = cy;
      CC_CC:   r = !cy;
      CC_MI:   r = n;
      CC_PL:   r = !n;
      CC_VS:   r = v;
      CC_VC:   r = !v;
      CC_HI:   r = cy && !z;
      CC_LS:   r = !cy || z;
      CC_GE:   r = (n == v);
      CC_LT:   r = (n != v);
      CC_GT:   r = !z && (n == v);
      CC_LE:   r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  // Returns {carry_out, result} for a shift by a register amount 0..255.
  function automatic logic [32:0] shift_reg(input logic [31:0] x, input logic [1:0] t,
                                            input logic [7:0] n, input logic cin);
    logic [32:0] tmp;
    logic [63:0] dbl;
    logic [4:0]  r;
    logic [32:0] ret;
    r   = n[4:0];
    tmp = '0;
    dbl = '0;
    ret = {cin, x};
    if (n != 8'd0) begin
      case (t)
        SH_LSL: begin
          if (n < 8'd32) begin
            tmp = {1'b0, x} << r;
            ret = tmp;
          end else if (n == 8'd32) begin
            ret = {x[0], 32'd0};
          end else begin
            ret = '0;
          end
        end
        SH_LSR: begin
          if (n < 8'd32) begin
            tmp = {x, 1'b0} >> r;
            ret = {tmp[0], tmp[32:1]};
          end else if (n == 8'd32) begin
            ret = {x[31], 32'd0};
          end else begin
            ret = '0;
          end
        end
        SH_ASR: begin
          if (n >= 8'd32) begin
            ret = {x[31], {32{x[31]}}};
          end else begin
            tmp = 33'($signed({x, 1'b0}) >>> r);
            ret = {tmp[0], tmp[32:1]};
          end
        end
        default: begin
          if (r == 5'd0) begin
            ret = {x[31], x};
          end else begin
            dbl = {x, x} >> r;
            ret = {dbl[31], dbl[31:0]};
          end
        end
      endcase
    end
    return ret;
  endfunction

  // Immediate amount: zero means 32 for LSR/ASR and RRX for ROR.
  function automatic logic [32:0] shift_imm(input logic [31:0] x, input logic [1:0] t,
                                            input logic [4:0] n, input logic cin);
    logic [32:0] ret;
    ret = shift_reg(x, t, {3'd0, n}, cin);
    if (n == 5'd0) begin
      case (t)
        SH_LSR, SH_ASR: ret = shift_reg(x, t, 8'd32, cin);
        SH_ROR:         ret = {x[0], cin, x[31:1]};
        default:        ret = {cin, x};
      endcase
    end
    return ret;
  endfunction

endpackage

### src/arm_ie_intf.sv
// Valid/ready channel interfaces for the item input and the result output.
// Field widths follow the block's item and result formats; no dependencies.
interface arm_ie_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] instruction;
  logic [4:0]  reg_index;
  logic [15:0] mem_address;
  logic [31:0] write_data;

  modport source(output valid, mode, instruction, reg_index, mem_address, write_data,
                 input ready);
  modport sink(input valid, mode, instruction, reg_index, mem_address, write_data,
               output ready);
endinterface

interface arm_ie_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic [31:0] pc_value;
  logic [3:0]  flag_bits;
  logic [47:0] executed_count;

  modport source(output valid, status, read_data, pc_value, flag_bits, executed_count,
                 input ready);
  modport sink(input valid, status, read_data, pc_value, flag_bits, executed_count,
               output ready);
endinterface

### src/arm_ie_regfile.sv
// Register file r0..r15: two synchronous read ports, one write port.
// Per-entry valid bits give the reset contents; uses arm_ie_pkg.
module arm_ie_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  ra_addr_i,
  input  logic [3:0]  rb_addr_i,
  output logic [31:0] ra_data_o,
  output logic [31:0] rb_data_o,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [31:0] wdata_i
);

  logic [31:0] mem [16];
  logic [15:0] valid_q;
  logic [31:0] ra_q, rb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    ra_q <= valid_q[ra_addr_i] ? mem[ra_addr_i] : arm_ie_pkg::reg_reset(ra_addr_i);
    rb_q <= valid_q[rb_addr_i] ? mem[rb_addr_i] : arm_ie_pkg::reg_reset(rb_addr_i);
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

### src/arm_ie_dmem.sv
// Byte data memory as four interleaved byte banks, one word at any alignment per access.
// Clears itself row by row after reset; uses arm_ie_pkg.
module arm_ie_dmem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [arm_ie_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [31:0]                   rd_data_o,
  input  arm_ie_pkg::dmem_wr_t          wr_i,
  output logic                          busy_o
);

  localparam int unsigned AW = arm_ie_pkg::ADDR_W;
  localparam int unsigned RW = arm_ie_pkg::ROW_W;

  logic          busy_q;
  logic [RW-1:0] clr_q;
  logic [1:0]    lo_q;
  logic [7:0]    bank_q [4];
  logic [RW-1:0] rrow [4];
  logic [RW-1:0] wrow [4];
  logic [7:0]    wbyte [4];
  logic          wen [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + RW'(1);
      if (clr_q == RW'(arm_ie_pkg::ROWS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Bank b holds the bytes whose address ends in b; byte k of a word lands in bank addr+k.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [1:0]    kr, kw;
      logic [AW-1:0] ar, aw;
      kr = 2'(b) - rd_addr_i[1:0];
      kw = 2'(b) - wr_i.addr[1:0];
      ar = rd_addr_i + AW'(kr);
      aw = wr_i.addr + AW'(kw);
      rrow[b]  = ar[AW-1:2];
      wrow[b]  = busy_q ? clr_q : aw[AW-1:2];
      wbyte[b] = busy_q ? 8'd0 : wr_i.data[8*kw +: 8];
      wen[b]   = busy_q || (wr_i.en && (wr_i.word || kw == 2'd0));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [arm_ie_pkg::ROWS];
    always_ff @(posedge clk_i) begin
      if (wen[b]) begin
        mem[wrow[b]] <= wbyte[b];
      end
      bank_q[b] <= mem[rrow[b]];
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= rd_addr_i[1:0];
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_data_o[8*k +: 8] = bank_q[2'(lo_q + 2'(k))];
    end
  end

  assign busy_o = busy_q;

endmodule

### src/arm_instruction_execute.sv
// Top level: sequencer, operand shifter, ALU and flags around the register file and data memory.
// Depends on arm_ie_pkg, arm_ie_intf, arm_ie_regfile and arm_ie_dmem.
//
//  port        dir  handshake      carries
//  in_i        in   valid/ready    mode, instruction, reg_index, mem_address, write_data
//  out_o       out  valid/ready    status, read_data, pc_value, flag_bits, executed_count
//  cfg_*_i     in   write enable   mem_limit (17 bits)
//
// Each item passes through register read, second register read plus memory read,
// then execute and write back; a load with base writeback adds a state for the base write.
// The next item is taken in the final cycle, so the pace is set by the registered
// register file and memory reads. After reset the memory clear runs through all MEM_BYTES/4
// rows (16384) before the first item is taken. A stalled output holds the item in
// its final cycle; one finished result waits in the output register meanwhile.
module arm_instruction_execute (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  arm_ie_in_if.sink                         in_i,
  arm_ie_out_if.source                      out_o,
  input  logic                              cfg_we_i,
  input  logic [arm_ie_pkg::LIM_W-1:0]      cfg_wdata_i
);

  localparam int unsigned AW = arm_ie_pkg::ADDR_W;
  localparam int unsigned LW = arm_ie_pkg::LIM_W;
  localparam int unsigned CW = arm_ie_pkg::CNT_W;

  arm_ie_pkg::fsm_e state_q, state_d;

  logic [2:0]  mode_q;
  logic [31:0] ins_q;
  logic [4:0]  ri_q;
  logic [15:0] ma_q;
  logic [31:0] wd_q;

  logic [31:0]   pc_q, pc_d;
  logic [31:0]   psr_q, psr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] lim_q;

  logic          ra15_q, rb15_q, rc15_q;
  logic [31:0]   a_q, m_q, addr_q, moved_q;
  logic          ok_q;

  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [31:0]   out_rdata_q, out_pc_q;
  logic [3:0]    out_flags_q;
  logic [CW-1:0] out_cnt_q;

  logic [3:0]  ra_addr, rb_addr;
  logic [31:0] ra_data, rb_data;
  logic        rf_we;
  logic [3:0]  rf_waddr;
  logic [31:0] rf_wdata;

  logic [AW-1:0]        dm_raddr;
  logic [31:0]          dm_rdata;
  arm_ie_pkg::dmem_wr_t dm_wr;
  logic                 dm_busy;

  logic accept, slot_free, need_ex2, ex_go, emit;

  // instruction fields
  logic [3:0]  f_cond, f_op, f_rn, f_rd, f_rs, f_rm;
  logic [1:0]  f_cls;
  logic        f_imm, f_s, f_ld, f_byte, f_up, f_pre, f_wb, f_link;
  logic        is_exec, cond_ok;

  assign f_cond = ins_q[31:28];
  assign f_imm  = ins_q[25];
  assign f_op   = ins_q[24:21];
  assign f_s    = ins_q[20];
  assign f_rn   = ins_q[19:16];
  assign f_rd   = ins_q[15:12];
  assign f_rs   = ins_q[11:8];
  assign f_rm   = ins_q[3:0];
  assign f_ld   = ins_q[20];
  assign f_wb   = ins_q[21];
  assign f_byte = ins_q[22];
  assign f_up   = ins_q[23];
  assign f_pre  = ins_q[24];
  assign f_link = ins_q[24];
  assign f_cls  = ins_q[27:26];

  assign is_exec = (mode_q == arm_ie_pkg::MODE_EXEC);
  assign cond_ok = arm_ie_pkg::cond_pass(f_cond, psr_q[31:28]);

  arm_ie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata)
  );

  arm_ie_dmem u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (dm_raddr),
    .rd_data_o (dm_rdata),
    .wr_i      (dm_wr),
    .busy_o    (dm_busy)
  );

  // ---------------------------------------------------------------- control
  assign slot_free = !out_valid_q || out_o.ready;
  assign need_ex2  = is_exec && cond_ok && (f_cls == arm_ie_pkg::CLS_MEM) && ok_q && f_ld
                     && (!f_pre || f_wb);

  always_comb begin
    in_i.ready = 1'b0;
    ex_go      = 1'b0;
    emit       = 1'b0;
    case (state_q)
      arm_ie_pkg::S_IDLE: in_i.ready = 1'b1;
      arm_ie_pkg::S_EX: begin
        ex_go      = need_ex2 || slot_free;
        emit       = !need_ex2 && slot_free;
        in_i.ready = emit;
      end
      arm_ie_pkg::S_EX2: begin
        ex_go      = slot_free;
        emit       = slot_free;
        in_i.ready = slot_free;
      end
      default: ;
    endcase
  end

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      arm_ie_pkg::S_CLEAR: if (!dm_busy) state_d = arm_ie_pkg::S_IDLE;
      arm_ie_pkg::S_IDLE:  if (accept) state_d = arm_ie_pkg::S_RD1;
      arm_ie_pkg::S_RD1:   state_d = arm_ie_pkg::S_RD2;
      arm_ie_pkg::S_RD2:   state_d = arm_ie_pkg::S_EX;
      arm_ie_pkg::S_EX: begin
        if (need_ex2) begin
          state_d = arm_ie_pkg::S_EX2;
        end else if (slot_free) begin
          state_d = accept ? arm_ie_pkg::S_RD1 : arm_ie_pkg::S_IDLE;
        end
      end
      arm_ie_pkg::S_EX2: begin
        if (slot_free) state_d = accept ? arm_ie_pkg::S_RD1 : arm_ie_pkg::S_IDLE;
      end
      default: state_d = arm_ie_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arm_ie_pkg::S_CLEAR;
      pc_q        <= '0;
      psr_q       <= '0;
      cnt_q       <= '0;
      lim_q       <= LW'(65536);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      psr_q   <= psr_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) lim_q <= cfg_wdata_i;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- read phases
  logic [31:0] a_val, m_val, c_val;
  logic [31:0] off_val, moved_val, addr_val;
  logic [32:0] lim_eff, end_addr;
  logic [32:0] sh_off;

  assign a_val = ra15_q ? pc_q : ra_data;
  assign m_val = rb15_q ? pc_q : rb_data;
  assign c_val = rc15_q ? pc_q : ra_data;

  always_comb begin
    ra_addr = f_rn;
    rb_addr = f_rm;
    if (state_q == arm_ie_pkg::S_RD1) begin
      ra_addr = is_exec ? f_rn : ri_q[3:0];
    end else if (state_q == arm_ie_pkg::S_RD2 || state_q == arm_ie_pkg::S_EX) begin
      // hold the second read while a stalled item waits in execute
      ra_addr = (f_cls == arm_ie_pkg::CLS_MEM) ? f_rd : f_rs;
    end
  end

  always_comb begin
    lim_eff = (33'(lim_q) > 33'(arm_ie_pkg::MEM_BYTES)) ? 33'(arm_ie_pkg::MEM_BYTES)
                                                         : 33'(lim_q);
    sh_off  = arm_ie_pkg::shift_imm(m_val, ins_q[6:5], ins_q[11:7], psr_q[29]);
    off_val = f_imm ? sh_off[31:0] : {20'd0, ins_q[11:0]};
    moved_val = f_up ? a_val + off_val : a_val - off_val;
    if (is_exec) begin
      addr_val = f_pre ? moved_val : a_val;
      end_addr = {1'b0, addr_val} + (f_byte ? 33'd1 : 33'd4);
    end else begin
      addr_val = {16'd0, ma_q};
      end_addr = {1'b0, addr_val} + 33'd4;
    end
    dm_raddr = (state_q == arm_ie_pkg::S_EX) ? addr_q[AW-1:0] : addr_val[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_i.mode;
      ins_q  <= in_i.instruction;
      ri_q   <= in_i.reg_index;
      ma_q   <= in_i.mem_address;
      wd_q   <= in_i.write_data;
    end
    if (state_q == arm_ie_pkg::S_RD1) begin
      ra15_q <= (ra_addr == arm_ie_pkg::REG_PC);
      rb15_q <= (rb_addr == arm_ie_pkg::REG_PC);
    end
    if (state_q == arm_ie_pkg::S_RD2) begin
      rc15_q  <= (ra_addr == arm_ie_pkg::REG_PC);
      a_q     <= a_val;
      m_q     <= m_val;
      addr_q  <= addr_val;
      moved_q <= moved_val;
      ok_q    <= (end_addr <= lim_eff);
    end
    if (emit) begin
      out_pc_q    <= pc_d;
      out_flags_q <= psr_d[31:28];
      out_cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------- execute
  logic [32:0] sh_res, sum;
  logic [31:0] b_val, res, imm_rot, br_off, ld_val;
  logic [4:0]  rot;
  logic        sc, carry, arith, is_test;
  logic [1:0]  status;
  logic [31:0] rdata;
  logic        w_en;
  logic [3:0]  w_idx;
  logic [31:0] w_val;

  always_comb begin
    rot     = {ins_q[11:8], 1'b0};
    imm_rot = (32'(ins_q[7:0]) >> rot) | (32'(ins_q[7:0]) << (6'd32 - 6'(rot)));
    sh_res  = '0;
    if (f_imm) begin
      b_val = imm_rot;
      sc    = (rot == 5'd0) ? psr_q[29] : imm_rot[31];
    end else begin
      if (ins_q[4]) begin
        sh_res = arm_ie_pkg::shift_reg(m_q, ins_q[6:5], c_val[7:0], psr_q[29]);
      end else begin
        sh_res = arm_ie_pkg::shift_imm(m_q, ins_q[6:5], ins_q[11:7], psr_q[29]);
      end
      b_val = sh_res[31:0];
      sc    = sh_res[32];
    end

    arith = 1'b1;
    sum   = '0;
    case (f_op)
      arm_ie_pkg::OP_SUB, arm_ie_pkg::OP_CMP: sum = {1'b0, a_q} + {1'b0, ~b_val} + 33'd1;
      arm_ie_pkg::OP_RSB: sum = {1'b0, b_val} + {1'b0, ~a_q} + 33'd1;
      arm_ie_pkg::OP_ADD, arm_ie_pkg::OP_CMN: sum = {1'b0, a_q} + {1'b0, b_val};
      arm_ie_pkg::OP_ADC: sum = {1'b0, a_q} + {1'b0, b_val} + 33'(psr_q[29]);
      arm_ie_pkg::OP_SBC: sum = {1'b0, a_q} + {1'b0, ~b_val} + 33'(psr_q[29]);
      arm_ie_pkg::OP_RSC: sum = {1'b0, b_val} + {1'b0, ~a_q} + 33'(psr_q[29]);
      default: arith = 1'b0;
    endcase

    res   = sum[31:0];
    carry = arith ? sum[32] : sc;
    case (f_op)
      arm_ie_pkg::OP_AND, arm_ie_pkg::OP_TST: res = a_q & b_val;
      arm_ie_pkg::OP_EOR, arm_ie_pkg::OP_TEQ: res = a_q ^ b_val;
      arm_ie_pkg::OP_ORR: res = a_q | b_val;
      arm_ie_pkg::OP_MOV: res = b_val;
      arm_ie_pkg::OP_BIC: res = a_q & ~b_val;
      arm_ie_pkg::OP_MVN: res = ~b_val;
      default: ;
    endcase
    is_test = (f_op[3:2] == 2'b10);

    br_off = {{6{ins_q[23]}}, ins_q[23:0], 2'b00};
    ld_val = f_byte ? {24'd0, dm_rdata[7:0]} : dm_rdata;
  end

  always_comb begin
    status = arm_ie_pkg::RES_DONE;
    rdata  = '0;
    pc_d   = pc_q;
    psr_d  = psr_q;
    cnt_d  = cnt_q;
    w_en   = 1'b0;
    w_idx  = f_rd;
    w_val  = res;
    dm_wr  = '{en: 1'b0, word: 1'b1, addr: addr_q[AW-1:0], data: wd_q};

    if (state_q == arm_ie_pkg::S_EX2) begin
      w_en  = ex_go;
      w_idx = f_rn;
      w_val = moved_q;
    end else if (state_q == arm_ie_pkg::S_EX) begin
      case (mode_q)
        arm_ie_pkg::MODE_EXEC: begin
          if (!cond_ok) begin
            status = arm_ie_pkg::RES_SKIP;
          end else begin
            case (f_cls)
              arm_ie_pkg::CLS_DATA: begin
                w_en = ex_go && !is_test;
                if ((f_s || is_test) && (f_rd != arm_ie_pkg::REG_PC || is_test) && ex_go) begin
                  psr_d[31] = res[31];
                  psr_d[30] = (res == 32'd0);
                  psr_d[29] = carry;
                end
              end
              arm_ie_pkg::CLS_MEM: begin
                if (!ok_q) begin
                  status = arm_ie_pkg::RES_RANGE;
                end else if (f_ld) begin
                  w_en  = ex_go;
                  w_val = ld_val;
                end else begin
                  dm_wr.en   = ex_go;
                  dm_wr.word = !f_byte;
                  dm_wr.data = c_val;
                  w_en       = ex_go && (!f_pre || f_wb);
                  w_idx      = f_rn;
                  w_val      = moved_q;
                end
              end
              arm_ie_pkg::CLS_BRANCH: begin
                if (f_imm) begin
                  w_en  = ex_go && f_link;
                  w_idx = arm_ie_pkg::REG_LR;
                  w_val = pc_q + 32'd4;
                  if (ex_go) pc_d = pc_q + 32'd8 + br_off;
                end else begin
                  status = arm_ie_pkg::RES_UNKNOWN;
                end
              end
              default: status = arm_ie_pkg::RES_UNKNOWN;
            endcase
          end
        end
        arm_ie_pkg::MODE_REG_WR: begin
          w_idx = ri_q[3:0];
          w_val = wd_q;
          w_en  = ex_go && !ri_q[4];
          if (ex_go && ri_q == arm_ie_pkg::IDX_PSR) psr_d = wd_q;
        end
        arm_ie_pkg::MODE_REG_RD: begin
          if (!ri_q[4]) begin
            rdata = a_q;
          end else if (ri_q == arm_ie_pkg::IDX_PSR) begin
            rdata = psr_q;
          end
        end
        arm_ie_pkg::MODE_MEM_WR: begin
          if (ok_q) begin
            dm_wr.en = ex_go;
          end else begin
            status = arm_ie_pkg::RES_RANGE;
          end
        end
        arm_ie_pkg::MODE_MEM_RD: begin
          if (ok_q) begin
            rdata = dm_rdata;
          end else begin
            status = arm_ie_pkg::RES_RANGE;
          end
        end
        default: status = arm_ie_pkg::RES_UNKNOWN;
      endcase
    end

    // r15 lives in pc_q; every other index goes to the register file
    if (w_en && w_idx == arm_ie_pkg::REG_PC) pc_d = w_val;
    rf_we    = w_en && (w_idx != arm_ie_pkg::REG_PC);
    rf_waddr = w_idx;
    rf_wdata = w_val;

    if (emit && is_exec) cnt_d = cnt_q + CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= (state_q == arm_ie_pkg::S_EX2) ? arm_ie_pkg::RES_DONE : status;
      out_rdata_q  <= (state_q == arm_ie_pkg::S_EX2) ? 32'd0 : rdata;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.read_data      = out_rdata_q;
  assign out_o.pc_value       = out_pc_q;
  assign out_o.flag_bits      = out_flags_q;
  assign out_o.executed_count = out_cnt_q;

endmodule
